>>> hdl/depth_tested_pixel_store_core_defines.svh
// Assertion helpers for the depth tested pixel store
`ifndef DEPTH_TESTED_PIXEL_STORE_CORE_DEFINES_SVH
`define DEPTH_TESTED_PIXEL_STORE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define DTPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dtps_pkg.sv
package dtps_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		ACT_PLOT        = 2'd0,
		ACT_CLEAR_ALL   = 2'd1,
		ACT_CLEAR_DEPTH = 2'd2,
		ACT_READ        = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_OOB        = 2'd1,
		STATUS_DEPTH_FAIL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic color_we;
		logic depth_we;
	} store_ctl_t;

endpackage

>>> hdl/dtps_if.sv
interface dtps_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         alpha;
	logic [23:0]        depth_in;

	modport source (output valid, action, pos_x, pos_y, red, green, blue, alpha, depth_in,
		input ready);
	modport sink (input valid, action, pos_x, pos_y, red, green, blue, alpha, depth_in,
		output ready);
endinterface

interface dtps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [7:0]  alpha_out;
	logic [23:0] depth_out;

	modport source (output valid, status, red_out, green_out, blue_out, alpha_out, depth_out,
		input ready);
	modport sink (input valid, status, red_out, green_out, blue_out, alpha_out, depth_out,
		output ready);
endinterface

>>> hdl/dtps_locate.sv
module dtps_locate #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int AW         = 18
) (
	input  logic [dtps_pkg::CFG_DATA_W-1:0] frame_width,
	input  logic [dtps_pkg::CFG_DATA_W-1:0] frame_height,
	input  logic signed [15:0]              pos_x,
	input  logic signed [15:0]              pos_y,
	output logic                            in_bounds,
	output logic [AW-1:0]                   addr
);
	import dtps_pkg::*;

	localparam logic [15:0] MaxW = 16'(MAX_WIDTH);
	localparam logic [15:0] MaxH = 16'(MAX_HEIGHT);

	logic [15:0] fw_ext;
	logic [15:0] fh_ext;
	logic [15:0] ext_w;
	logic [15:0] ext_h;
	logic [31:0] lin;

	assign fw_ext = {{(16 - CFG_DATA_W){1'b0}}, frame_width};
	assign fh_ext = {{(16 - CFG_DATA_W){1'b0}}, frame_height};
	// register values above the store size saturate
	assign ext_w  = (fw_ext > MaxW) ? MaxW : fw_ext;
	assign ext_h  = (fh_ext > MaxH) ? MaxH : fh_ext;

	assign in_bounds = !pos_x[15] && !pos_y[15]
		&& ({1'b0, pos_x[14:0]} < ext_w) && ({1'b0, pos_y[14:0]} < ext_h);

	// row-major with a fixed pitch, independent of the frame registers
	assign lin  = 32'(pos_y[14:0]) * 32'(MAX_WIDTH) + 32'(pos_x[14:0]);
	assign addr = lin[AW-1:0];

endmodule

>>> hdl/dtps_store.sv
module dtps_store #(
	parameter int ENTRIES = 262144,
	parameter int AW      = 18,
	parameter int DW      = 24
) (
	input  logic                   clk,
	input  dtps_pkg::store_ctl_t   ctl,
	input  logic [AW-1:0]          rd_addr,
	input  logic [AW-1:0]          wr_addr,
	input  logic [31:0]            wr_color,
	input  logic [DW-1:0]          wr_depth,
	output logic [31:0]            rd_color,
	output logic [DW-1:0]          rd_depth
);
	import dtps_pkg::*;

	logic [31:0]   color_mem [ENTRIES];
	logic [DW-1:0] depth_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.color_we) begin
			color_mem[wr_addr] <= wr_color;
		end
		if (ctl.rd_en) begin
			rd_color <= color_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.depth_we) begin
			depth_mem[wr_addr] <= wr_depth;
		end
		if (ctl.rd_en) begin
			rd_depth <= depth_mem[rd_addr];
		end
	end

endmodule

>>> hdl/depth_tested_pixel_store_core.sv
// Plot and read: the store is read as the input word is taken; the check state then
// loads the result word, waiting while the output register is full. Ready is high
// only in idle, so no new word is taken during a read-compare-write. Out-of-bounds
// plot or read: no store access; the finish state gives the status word. Clears: one
// memory entry written per cycle, then a status word. Reset: async, active low; then a
// sweep of all entries sets color to zero and depth to far while input is held off.
`include "depth_tested_pixel_store_core_defines.svh"

module depth_tested_pixel_store_core #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int DEPTH_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dtps_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dtps_pkg::CFG_DATA_W-1:0]   cfg_data,
	dtps_in_if.sink                           in_ch,
	dtps_out_if.source                        out_ch
);
	import dtps_pkg::*;

	localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] LastAddr = AW'(ENTRIES - 1);
	localparam logic [DEPTH_BITS-1:0] DepthFar = '1;

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] frame_width_q;
	logic [CFG_DATA_W-1:0] frame_height_q;

	logic [AW-1:0]         sweep_cnt_q;
	logic [31:0]           sweep_color_q;
	logic [DEPTH_BITS-1:0] sweep_depth_q;
	logic                  sweep_color_en_q;
	logic                  sweep_report_q;

	action_t               act_q;
	logic [AW-1:0]         addr_q;
	logic [31:0]           color_q;
	logic [DEPTH_BITS-1:0] depth_q;
	status_t               status_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [31:0]           out_color_q;
	logic [23:0]           out_depth_q;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	status_t               out_status_d;
	logic [31:0]           out_color_d;
	logic [23:0]           out_depth_d;

	logic                  loc_in_bounds;
	logic [AW-1:0]         loc_addr;
	action_t               in_act;
	logic [31:0]           in_color;
	logic [31:0]           depth_in_ext;
	logic [DEPTH_BITS-1:0] depth_in_m;
	logic [31:0]           rd_depth_ext;

	store_ctl_t            store_ctl;
	logic [AW-1:0]         wr_addr;
	logic [31:0]           wr_color;
	logic [DEPTH_BITS-1:0] wr_depth;
	logic [31:0]           rd_color;
	logic [DEPTH_BITS-1:0] rd_depth;

	dtps_locate #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW)
	) u_locate (
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pos_x        (in_ch.pos_x),
		.pos_y        (in_ch.pos_y),
		.in_bounds    (loc_in_bounds),
		.addr         (loc_addr)
	);

	dtps_store #(
		.ENTRIES (ENTRIES),
		.AW      (AW),
		.DW      (DEPTH_BITS)
	) u_store (
		.clk      (clk),
		.ctl      (store_ctl),
		.rd_addr  (loc_addr),
		.wr_addr  (wr_addr),
		.wr_color (wr_color),
		.wr_depth (wr_depth),
		.rd_color (rd_color),
		.rd_depth (rd_depth)
	);

	assign in_act       = action_t'(in_ch.action);
	assign in_color     = {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};
	assign depth_in_ext = 32'(in_ch.depth_in);
	assign depth_in_m   = depth_in_ext[DEPTH_BITS-1:0];
	assign rd_depth_ext = 32'(rd_depth);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign wr_addr  = (state_q == ST_SWEEP) ? sweep_cnt_q : addr_q;
	assign wr_color = (state_q == ST_SWEEP) ? sweep_color_q : color_q;
	assign wr_depth = (state_q == ST_SWEEP) ? sweep_depth_q : depth_q;

	always_comb begin
		state_d      = state_q;
		store_ctl    = '0;
		out_load     = 1'b0;
		out_status_d = STATUS_OK;
		out_color_d  = '0;
		out_depth_d  = '0;
		case (state_q)
			ST_SWEEP: begin
				store_ctl.color_we = sweep_color_en_q;
				store_ctl.depth_we = 1'b1;
				if (sweep_cnt_q == LastAddr) begin
					state_d = sweep_report_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_act)
						ACT_PLOT, ACT_READ: begin
							if (loc_in_bounds) begin
								store_ctl.rd_en = 1'b1;
								state_d = ST_CHECK;
							end else begin
								state_d = ST_FINISH;
							end
						end
						default: state_d = ST_SWEEP;
					endcase
				end
			end
			ST_CHECK: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (act_q == ACT_PLOT) begin
						if (depth_q < rd_depth) begin
							store_ctl.color_we = 1'b1;
							store_ctl.depth_we = 1'b1;
						end else begin
							out_status_d = STATUS_DEPTH_FAIL;
						end
					end else begin
						out_color_d = rd_color;
						out_depth_d = rd_depth_ext[23:0];
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = status_q;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_DATA_W'(512);
			frame_height_q <= CFG_DATA_W'(512);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sweep setup; reset values describe the power-up clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q      <= '0;
			sweep_color_q    <= '0;
			sweep_depth_q    <= DepthFar;
			sweep_color_en_q <= 1'b1;
			sweep_report_q   <= 1'b0;
		end else if (state_q == ST_SWEEP) begin
			sweep_cnt_q <= sweep_cnt_q + AW'(1);
		end else if (accept && (in_act == ACT_CLEAR_ALL || in_act == ACT_CLEAR_DEPTH)) begin
			sweep_cnt_q      <= '0;
			sweep_color_q    <= in_color;
			sweep_depth_q    <= (in_act == ACT_CLEAR_ALL) ? DepthFar : depth_in_m;
			sweep_color_en_q <= (in_act == ACT_CLEAR_ALL);
			sweep_report_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= in_act;
			addr_q   <= loc_addr;
			color_q  <= in_color;
			depth_q  <= depth_in_m;
			status_q <= ((in_act == ACT_PLOT || in_act == ACT_READ) && !loc_in_bounds)
				? STATUS_OOB : STATUS_OK;
		end
	end

	// output register: next word may be taken while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_color_q  <= out_color_d;
			out_depth_q  <= out_depth_d;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.status    = out_status_q;
	assign out_ch.red_out   = out_color_q[7:0];
	assign out_ch.green_out = out_color_q[15:8];
	assign out_ch.blue_out  = out_color_q[23:16];
	assign out_ch.alpha_out = out_color_q[31:24];
	assign out_ch.depth_out = out_depth_q;

	`DTPS_ASSERT_IMP(a_write_only_in_sweep_or_check, store_ctl.depth_we, state_q == ST_SWEEP || state_q == ST_CHECK, "store written outside sweep or check")
	`DTPS_ASSERT_IMP(a_plot_write_nearer, state_q == ST_CHECK && store_ctl.depth_we, act_q == ACT_PLOT && depth_q < rd_depth, "plot write without passing depth test")
	`DTPS_ASSERT_NEXT(a_check_yields_word, state_q == ST_CHECK && out_free, out_valid_q && state_q == ST_IDLE, "checked word not presented")

endmodule
